[hw/rtl/cma_pkg.sv]
// ----------------------------------------------------------------------------
// Centred moving average: shared package
// Types and constants used by the cells, the divider stages, the configuration
// interface and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cma_pkg;

  // Width of the radius configuration register.
  localparam int unsigned RADIUS_W = 5;

  // Quotient bits resolved by one divider stage.
  localparam int unsigned DIV_STEPS = 8;

  // Control group carried along the divider pipeline.
  typedef struct packed {
    logic valid;
    logic neg;
    logic final_res;
  } cma_ctl_t;

  // Control group that the top level hands to every window cell.
  typedef struct packed {
    logic shift;
    logic clear;
    logic entry;
    logic above;
  } cma_cell_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/cma_cfg_if.sv]
// ----------------------------------------------------------------------------
// Centred moving average: configuration write channel
// Carries the radius register write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cma_cfg_if import cma_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [RADIUS_W-1:0] radius;

  modport source (output valid, output radius, input ready);
  modport sink   (input valid, input radius, output ready);

endinterface

`default_nettype wire

[hw/rtl/cma_in_if.sv]
// ----------------------------------------------------------------------------
// Centred moving average: sample input channel
// One beat carries one sample and the last-of-capture flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cma_in_if #(
  parameter int unsigned SAMPLE_BITS = 32
) ();

  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);

endinterface

`default_nettype wire

[hw/rtl/cma_out_if.sv]
// ----------------------------------------------------------------------------
// Centred moving average: result output channel
// One beat carries one smoothed sample and the last-of-capture flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cma_out_if #(
  parameter int unsigned SAMPLE_BITS = 32
) ();

  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] average;
  logic                   final_res;

  modport source (output valid, output average, output final_res, input ready);
  modport sink   (input valid, input average, input final_res, output ready);

endinterface

`default_nettype wire

[hw/rtl/cma_cell.sv]
// ----------------------------------------------------------------------------
// Centred moving average: window cell
// Holds one sample of the window and its valid flag; loads from its upper
// neighbour, or from the incoming sample when it is the entry cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cma_cell import cma_pkg::*; #(
  parameter int unsigned DATA_W = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cma_cell_ctl_t     ctl_i,
  input  wire logic [DATA_W-1:0] new_data_i,
  input  wire logic              new_vld_i,
  input  wire logic [DATA_W-1:0] nb_data_i,
  input  wire logic              nb_vld_i,
  output logic      [DATA_W-1:0] data_o,
  output logic                   vld_o,
  output logic                   vld_nxt_o
);

  logic [DATA_W-1:0] data_q, data_d;
  logic              vld_q;

  // Cells above the entry point hold nothing for the current radius.
  assign data_d    = ctl_i.entry ? new_data_i : nb_data_i;
  assign vld_nxt_o = ctl_i.entry ? new_vld_i : (nb_vld_i && !ctl_i.above);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.clear) begin
      vld_q <= 1'b0;
    end else if (ctl_i.shift) begin
      vld_q <= vld_nxt_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;
  assign vld_o  = vld_q;

endmodule

`default_nettype wire

[hw/rtl/cma_div_stage.sv]
// ----------------------------------------------------------------------------
// Centred moving average: divider stage
// Resolves DIV_STEPS quotient bits of a restoring division by a narrow
// divisor and registers the partial result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cma_div_stage import cma_pkg::*; #(
  parameter int unsigned CNT_W = 6,
  parameter int unsigned NUM_W = 40
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire cma_ctl_t         ctl_i,
  input  wire logic [CNT_W-1:0] rem_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [CNT_W-1:0] den_i,
  output cma_ctl_t              ctl_o,
  output logic      [CNT_W-1:0] rem_o,
  output logic      [NUM_W-1:0] num_o,
  output logic      [CNT_W-1:0] den_o
);

  cma_ctl_t         ctl_q;
  logic [CNT_W-1:0] rem_q, rem_d, den_q;
  logic [NUM_W-1:0] num_q, num_d;

  // The numerator register shifts left; quotient bits enter at the bottom.
  always_comb begin
    logic [CNT_W:0] trial;
    rem_d = rem_i;
    num_d = num_i;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial = {rem_d, num_d[NUM_W-1]};
      num_d = {num_d[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_i}) begin
        rem_d    = CNT_W'(trial - {1'b0, den_i});
        num_d[0] = 1'b1;
      end else begin
        rem_d = CNT_W'(trial);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      num_q <= num_d;
      den_q <= den_i;
    end
  end

  assign ctl_o = ctl_q;
  assign rem_o = rem_q;
  assign num_o = num_q;
  assign den_o = den_q;

endmodule

`default_nettype wire

[hw/rtl/centered_moving_average_unit.sv]
// ----------------------------------------------------------------------------
// Centred moving average unit
// Result path: the division request register, the divider stages and the
// output register follow the beat that completes a window.
// Throughput: one sample per cycle while the output is not stalled; a beat
// marked last closes the input while the window cells drain, unless radius is 0.
// Reset: asynchronous, active low; radius returns to 1, the window is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Structure
//   A row of 2*MAX_RADIUS+1 window cells forms a shift line. A new sample is
//   written into the entry cell, number 2*radius, and every cell below loads
//   from its upper neighbour, so cell 0 always holds the oldest sample of the
//   window and cell radius the centre. Valid flags mark the samples that
//   exist in the current capture, which cuts windows short at the start.
//   A running sum and a sample count follow the window: each shift adds the
//   entering sample and drops cell 0.
//
//   A result is due whenever the centre cell becomes valid. After a beat
//   marked last, radius bubble shifts push the remaining samples through the
//   centre, and the final shift clears the whole row, the sum and the count.
//
//   The sum is divided by the count in a pipeline of restoring divider
//   stages, eight quotient bits each. A negative sum is fed in as its one's
//   complement, which avoids a wide negation ahead of the divider; the output
//   register turns the quotient back into a truncated negative mean.
//
//   The whole datapath advances when the output register is free or is being
//   emptied, so a stalled result freezes the pipeline and holds the input.

module centered_moving_average_unit import cma_pkg::*; #(
  parameter int unsigned MAX_RADIUS  = 16,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  cma_cfg_if.sink       cfg_i,
  cma_in_if.sink        smp_in_i,
  cma_out_if.source     avg_out_o
);

  localparam int unsigned DEPTH = 2 * MAX_RADIUS + 1;
  localparam int unsigned RAD_W = $clog2(MAX_RADIUS + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = SAMPLE_BITS + CNT_W;
  localparam int unsigned NST   = (SUM_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned NUM_W = NST * DIV_STEPS;

  // --------------------------------------------------------------------------
  // Configuration and capture control
  // --------------------------------------------------------------------------
  logic [RADIUS_W-1:0] radius_q;
  logic [RAD_W-1:0]    cap_q;       // radius latched with the first sample
  logic                active_q;    // a capture is under way
  logic                flushing_q;  // draining after the last sample
  logic [RAD_W-1:0]    fcnt_q;      // bubble shifts still to go
  logic [RAD_W-1:0]    r_clamp, r_eff;
  logic                en, accept, flush_step, shift, end_cap, emit, fin;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_W'(1);
    end else if (cfg_i.valid) begin
      radius_q <= cfg_i.radius;
    end
  end

  // A radius beyond what the row can hold acts as the largest one.
  assign r_clamp = (radius_q > RADIUS_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                      : RAD_W'(radius_q);
  // The first sample of a capture already uses the new radius.
  assign r_eff   = active_q ? cap_q : r_clamp;

  // The datapath moves when the output register can take a new beat.
  logic out_valid_q;
  assign en             = !out_valid_q || avg_out_o.ready;
  assign smp_in_i.ready = en && !flushing_q;
  assign accept         = smp_in_i.valid && smp_in_i.ready;
  assign flush_step     = en && flushing_q;
  assign shift          = accept || flush_step;

  // The capture ends on the last bubble shift, or at once for radius zero.
  assign end_cap = (flush_step && (fcnt_q == RAD_W'(1)))
                || (accept && smp_in_i.last && (r_eff == '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= RAD_W'(1);
      active_q   <= 1'b0;
      flushing_q <= 1'b0;
      fcnt_q     <= '0;
    end else begin
      if (accept && !active_q) begin
        cap_q <= r_clamp;
      end
      if (end_cap) begin
        active_q   <= 1'b0;
        flushing_q <= 1'b0;
      end else if (accept) begin
        active_q <= 1'b1;
        if (smp_in_i.last) begin
          flushing_q <= 1'b1;
          fcnt_q     <= r_eff;
        end
      end else if (flush_step) begin
        fcnt_q <= RAD_W'(fcnt_q - RAD_W'(1));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Row of window cells
  // --------------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] cell_data [DEPTH];
  logic                   cell_vld  [DEPTH];
  logic                   vld_nxt   [DEPTH];
  logic [RAD_W:0]         entry_idx;

  assign entry_idx = {r_eff, 1'b0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cma_cell_ctl_t          cctl;
    logic [SAMPLE_BITS-1:0] nb_data;
    logic                   nb_vld;

    if (i == DEPTH - 1) begin : g_top
      assign nb_data = '0;
      assign nb_vld  = 1'b0;
    end else begin : g_mid
      assign nb_data = cell_data[i+1];
      assign nb_vld  = cell_vld[i+1];
    end

    assign cctl.shift = shift;
    assign cctl.clear = end_cap;
    assign cctl.entry = (entry_idx == (RAD_W + 1)'(i));
    assign cctl.above = (entry_idx < (RAD_W + 1)'(i));

    cma_cell #(
      .DATA_W (SAMPLE_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (cctl),
      .new_data_i (smp_in_i.sample),
      .new_vld_i  (accept),
      .nb_data_i  (nb_data),
      .nb_vld_i   (nb_vld),
      .data_o     (cell_data[i]),
      .vld_o      (cell_vld[i]),
      .vld_nxt_o  (vld_nxt[i])
    );
  end

  // A result is due when a sample arrives in the centre cell.
  assign emit = shift && vld_nxt[IDX_W'(r_eff)];
  assign fin  = end_cap;

  // --------------------------------------------------------------------------
  // Running window sum and sample count
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0] sum_q, sum_d, add_term, sub_term;
  logic        [CNT_W-1:0] cnt_q, cnt_d;

  assign add_term = accept
    ? {{(SUM_W - SAMPLE_BITS){smp_in_i.sample[SAMPLE_BITS-1]}}, smp_in_i.sample}
    : '0;
  assign sub_term = cell_vld[0]
    ? {{(SUM_W - SAMPLE_BITS){cell_data[0][SAMPLE_BITS-1]}}, cell_data[0]}
    : '0;
  assign sum_d = sum_q + add_term - sub_term;
  assign cnt_d = cnt_q + CNT_W'(accept) - CNT_W'(cell_vld[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (end_cap) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (shift) begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  // --------------------------------------------------------------------------
  // Division request register
  // --------------------------------------------------------------------------
  cma_ctl_t         req_ctl_q;
  logic [SUM_W-1:0] req_num_q;
  logic [CNT_W-1:0] req_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ctl_q <= '0;
    end else if (en) begin
      req_ctl_q.valid     <= emit;
      req_ctl_q.neg       <= sum_d[SUM_W-1];
      req_ctl_q.final_res <= fin;
    end
  end

  // A negative sum goes in as its one's complement, that is magnitude minus one.
  always_ff @(posedge clk_i) begin
    if (en) begin
      req_num_q <= sum_d ^ {SUM_W{sum_d[SUM_W-1]}};
      req_den_q <= cnt_d;
    end
  end

  // --------------------------------------------------------------------------
  // Divider pipeline
  // --------------------------------------------------------------------------
  cma_ctl_t         st_ctl [NST+1];
  logic [CNT_W-1:0] st_rem [NST+1];
  logic [NUM_W-1:0] st_num [NST+1];
  logic [CNT_W-1:0] st_den [NST+1];

  assign st_ctl[0] = req_ctl_q;
  assign st_rem[0] = '0;
  assign st_num[0] = NUM_W'(req_num_q);
  assign st_den[0] = req_den_q;

  for (genvar s = 0; s < NST; s++) begin : g_div
    cma_div_stage #(
      .CNT_W (CNT_W),
      .NUM_W (NUM_W)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (st_ctl[s]),
      .rem_i  (st_rem[s]),
      .num_i  (st_num[s]),
      .den_i  (st_den[s]),
      .ctl_o  (st_ctl[s+1]),
      .rem_o  (st_rem[s+1]),
      .num_o  (st_num[s+1]),
      .den_o  (st_den[s+1])
    );
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  // For a negative sum the divider saw magnitude minus one. The true quotient
  // is one higher exactly when the remainder came out one below the divisor,
  // so the mean is the complement of the quotient, plus one unless exact.
  logic [SAMPLE_BITS-1:0] quo, avg_d, avg_q;
  logic                   exact;
  logic                   fin_q;

  assign quo   = st_num[NST][SAMPLE_BITS-1:0];
  assign exact = (({1'b0, st_rem[NST]} + (CNT_W + 1)'(1)) == {1'b0, st_den[NST]});
  assign avg_d = st_ctl[NST].neg ? (~quo + SAMPLE_BITS'(!exact)) : quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= st_ctl[NST].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      avg_q <= avg_d;
      fin_q <= st_ctl[NST].final_res;
    end
  end

  assign avg_out_o.valid     = out_valid_q;
  assign avg_out_o.average   = avg_q;
  assign avg_out_o.final_res = fin_q;

endmodule

`default_nettype wire

[hw/rtl/cma_checker.sv]
// ----------------------------------------------------------------------------
// Centred moving average: port checker
// Watches the ports of the top level over time and is bound to it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cma_checker #(
  parameter int unsigned SAMPLE_BITS = 32
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_ready_i,
  input wire logic                   in_last_i,
  input wire logic                   out_valid_i,
  input wire logic                   out_ready_i,
  input wire logic [SAMPLE_BITS-1:0] out_average_i,
  input wire logic                   out_final_i
);

  // A stalled result beat stays put.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_average_i)
                                    && $stable(out_final_i))
    else $error("result beat changed while stalled");

  // A stalled output freezes the whole pipeline, so no sample is taken.
  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while the output is stalled");

  // Only a last beat starts a drain; any other beat leaves the input open
  // unless the output stalls.
  a_no_drain_mid_capture : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_last_i |=>
      in_ready_i || (out_valid_i && !out_ready_i))
    else $error("input closed in the middle of a capture");

endmodule

bind centered_moving_average_unit cma_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_cma_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (smp_in_i.valid),
  .in_ready_i    (smp_in_i.ready),
  .in_last_i     (smp_in_i.last),
  .out_valid_i   (avg_out_o.valid),
  .out_ready_i   (avg_out_o.ready),
  .out_average_i (avg_out_o.average),
  .out_final_i   (avg_out_o.final_res)
);

`default_nettype wire
